### design/abfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abfc_pkg
// Shared widths, operation codes and pixel constants for the alpha blend
// frame compositor.
// ----------------------------------------------------------------------------
package abfc_pkg;

    localparam int unsigned FRAME_WIDTH_DEF  = 512;
    localparam int unsigned FRAME_HEIGHT_DEF = 256;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned POS_W    = 13;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned AW_W     = 10;
    localparam int unsigned AH_W     = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PROD_W   = 16;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [PIXEL_W-1:0]   t_pixel;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_kind KIND_OPAQUE = 2'd0;
    localparam t_kind KIND_ALPHA  = 2'd1;
    localparam t_kind KIND_CURSOR = 2'd2;
    localparam t_kind KIND_READ   = 2'd3;

    localparam t_cfg_idx CFG_ACTIVE_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_ACTIVE_HEIGHT = 2'd1;

    localparam logic [CODE_W-1:0] CURSOR_BLACK = 8'd1;
    localparam logic [CODE_W-1:0] CURSOR_WHITE = 8'd2;

    localparam t_pixel ARGB_BLACK = 32'hFF00_0000;
    localparam t_pixel ARGB_WHITE = 32'hFFFF_FFFF;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    localparam logic [AW_W-1:0] ACTIVE_WIDTH_RST  = 10'd512;
    localparam logic [AH_W-1:0] ACTIVE_HEIGHT_RST = 9'd256;

    // Exact floor(v / 255) for v up to 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W:0] v);
        logic [PROD_W:0] t;
        t = v + 17'd1 + (v >> 8);
        return t[PROD_W-1:8];
    endfunction

endpackage

### design/alpha_blend_frame_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_frame_compositor
// Frame store compositor: opaque writes, ARGB over-compositing, cursor cells
// and pixel read-back on a row-major frame store in one synchronous RAM.
// ----------------------------------------------------------------------------
// Each word is taken when i_start is high and o_busy low. Its result shows on
// o_read_pixel and o_clipped with o_done high for exactly one cycle, once the
// calc, address and multiply states are through; the receiver cannot stall,
// so it must take the word in that cycle. No new word is taken while o_busy
// is high: the sequence address multiply, RAM read, channel multiply, then
// blend and RAM write back runs per word; its last step overlaps the next
// accept. Clipped words change nothing and return zero with o_clipped set.
// Frame store content is undefined until written; there is no clearing pass.
module alpha_blend_frame_compositor
    import abfc_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic [PIXEL_W-1:0]    i_pixel_value,
    input  logic [CODE_W-1:0]     i_cursor_code,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic [PIXEL_W-1:0]    o_read_pixel,
    output logic                  o_clipped
);

    localparam int unsigned DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned ROW_W  = AW_W + AH_W;
    localparam int unsigned SUM_W  = ROW_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [AW_W-1:0] r_active_width;
    logic [AH_W-1:0] r_active_height;

    t_kind               r_kind;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    t_pixel              r_pixel_value;
    logic [CODE_W-1:0]   r_cursor_code;

    logic                r_clip;
    logic [ROW_W-1:0]    r_row_base;
    logic [ADDR_W-1:0]   r_addr;
    t_pixel              r_rd_data;
    logic [PROD_W-1:0]   r_prod_s [3];
    logic [PROD_W-1:0]   r_prod_d [3];

    logic [PIXEL_W-1:0]  r_frame_store [DEPTH];

    logic [AW_W-1:0]     w_width;
    logic [AH_W-1:0]     w_height;
    logic                w_clip;
    logic                w_accept;
    logic [ADDR_W-1:0]   w_addr;
    logic                w_we;
    t_pixel              w_wdata;
    t_pixel              w_blend;
    logic [CHAN_W-1:0]   w_alpha;

    // Saturate the active area at the frame size.
    assign w_width  = (32'(r_active_width) > FRAME_WIDTH) ? AW_W'(FRAME_WIDTH)
                                                          : r_active_width;
    assign w_height = (32'(r_active_height) > FRAME_HEIGHT) ? AH_W'(FRAME_HEIGHT)
                                                            : r_active_height;

    assign w_clip = r_pos_x[POS_W-1] || r_pos_y[POS_W-1]
                 || ($unsigned(r_pos_x) >= POS_W'(w_width))
                 || ($unsigned(r_pos_y) >= POS_W'(w_height));

    assign o_busy   = (r_state != S_IDLE) && (r_state != S_WB);
    assign w_accept = i_start && !o_busy;
    assign w_alpha  = r_pixel_value[PIXEL_W-1 -: CHAN_W];

    // Not clipped, so x and y sit below the active width and height.
    assign w_addr = ADDR_W'(SUM_W'(r_row_base) + SUM_W'(r_pos_x[AW_W-1:0]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CALC;
            S_CALC: n_state = S_ADDR;
            S_ADDR: n_state = S_MUL;
            S_MUL:  n_state = S_WB;
            S_WB:   n_state = w_accept ? S_CALC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_active_width  <= ACTIVE_WIDTH_RST;
            r_active_height <= ACTIVE_HEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data[AW_W-1:0];
                    CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data[AH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind        <= i_kind;
            r_pos_x       <= i_pos_x;
            r_pos_y       <= i_pos_y;
            r_pixel_value <= i_pixel_value;
            r_cursor_code <= i_cursor_code;
        end
        if (r_state == S_CALC) begin
            r_clip     <= w_clip;
            r_row_base <= ROW_W'(r_pos_y[AH_W-1:0]) * ROW_W'(w_width);
        end
        if (r_state == S_ADDR) begin
            r_addr <= w_addr;
        end
        if (r_state == S_MUL) begin
            for (int c = 0; c < 3; c++) begin
                r_prod_s[c] <= PROD_W'(r_pixel_value[CHAN_W*c +: CHAN_W])
                             * PROD_W'(w_alpha);
                r_prod_d[c] <= PROD_W'(r_rd_data[CHAN_W*c +: CHAN_W])
                             * PROD_W'(ALPHA_OPAQUE - w_alpha);
            end
        end
    end

    // Frame store: one read in the address step, write back at the end.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_rd_data <= r_frame_store[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_frame_store[r_addr] <= w_wdata;
        end
    end

    always_comb begin
        w_blend = ARGB_BLACK;
        for (int c = 0; c < 3; c++) begin
            w_blend[CHAN_W*c +: CHAN_W] =
                div255((PROD_W+1)'(r_prod_s[c]) + (PROD_W+1)'(r_prod_d[c]));
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_pixel_value;
        if (r_state == S_WB && !r_clip) begin
            unique case (r_kind)
                KIND_OPAQUE: w_we = 1'b1;
                KIND_ALPHA: begin
                    if (w_alpha == ALPHA_OPAQUE) begin
                        w_we = 1'b1;
                    end else if (w_alpha != ALPHA_CLEAR) begin
                        w_we    = 1'b1;
                        w_wdata = w_blend;
                    end
                end
                KIND_CURSOR: begin
                    if (r_cursor_code == CURSOR_BLACK) begin
                        w_we    = 1'b1;
                        w_wdata = ARGB_BLACK;
                    end else if (r_cursor_code == CURSOR_WHITE) begin
                        w_we    = 1'b1;
                        w_wdata = ARGB_WHITE;
                    end
                end
                KIND_READ: w_we = 1'b0;
                default: w_we = 1'b0;
            endcase
        end
    end

    assign o_done       = (r_state == S_WB);
    assign o_clipped    = o_done && r_clip;
    assign o_read_pixel = (o_done && !r_clip && r_kind == KIND_READ) ? r_rd_data
                                                                      : '0;

`ifndef SYNTH
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_done)
        else $error("result strobe missing four cycles after accept");

    a_done_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_clip_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_clip) |-> (!w_we && o_read_pixel == '0))
        else $error("clipped word touched the frame store or returned data");
`endif

endmodule

### tb/sv/alpha_blend_frame_compositor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_frame_compositor_test
// Self-checking bench for the frame store compositor. A table of directed
// pixel words is followed by random traffic over several active-area settings;
// every returned word is compared with its table entry or a shadow frame store
// that mirrors writes, composites, cursor cells, reads and clipping.
// ----------------------------------------------------------------------------
module alpha_blend_frame_compositor_test;
    import abfc_pkg::*;

    localparam t_cfg_idx CFG_SPARE_A = 2'd2;
    localparam t_cfg_idx CFG_SPARE_B = 2'd3;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_WORDS    = 210;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        t_kind                    kind;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        t_pixel                   pix;
        logic [CODE_W-1:0]        code;
    } t_pixel_word;

    typedef struct {
        t_pixel pix;
        logic   clip;
    } t_scan_result;

    typedef struct {
        t_pixel_word  wd;
        bit           known;
        t_scan_result res;
    } t_directed_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [KIND_W-1:0]     i_kind;
    logic signed [POS_W-1:0] i_pos_x;
    logic signed [POS_W-1:0] i_pos_y;
    logic [PIXEL_W-1:0]    i_pixel_value;
    logic [CODE_W-1:0]     i_cursor_code;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [PIXEL_W-1:0]    o_read_pixel;
    logic                  o_clipped;

    alpha_blend_frame_compositor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_value (i_pixel_value),
        .i_cursor_code (i_cursor_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_read_pixel  (o_read_pixel),
        .o_clipped     (o_clipped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pixel          shadow_frame [int];
    logic [AW_W-1:0] width_reg  = ACTIVE_WIDTH_RST;
    logic [AH_W-1:0] height_reg = ACTIVE_HEIGHT_RST;
    t_scan_result    due_results [$];
    t_directed_row   directed_rows [$];
    int              mismatch_cnt = 0;
    int              idle_cycles  = 0;
    int              burst_left   = 0;

    function automatic int act_w();
        return (width_reg > FRAME_WIDTH_DEF) ? int'(FRAME_WIDTH_DEF) : int'(width_reg);
    endfunction

    function automatic int act_h();
        return (height_reg > FRAME_HEIGHT_DEF) ? int'(FRAME_HEIGHT_DEF) : int'(height_reg);
    endfunction

    function automatic bit off_screen(input int xi, input int yi);
        return xi < 0 || yi < 0 || xi >= act_w() || yi >= act_h();
    endfunction

    // Apply one word to the shadow store and return what the block should answer.
    function automatic t_scan_result composite_pixel(input t_pixel_word wd);
        t_scan_result r;
        int           xi;
        int           yi;
        int           addr;
        int           ch;
        int           s;
        int           dc;
        logic [7:0]   alpha;
        t_pixel       dst;
        t_pixel       blended;
        r.pix  = '0;
        r.clip = 1'b0;
        xi     = int'(wd.pos_x);
        yi     = int'(wd.pos_y);
        if (off_screen(xi, yi)) begin
            r.clip = 1'b1;
            return r;
        end
        addr  = yi * act_w() + xi;
        alpha = wd.pix[31:24];
        case (wd.kind)
            KIND_OPAQUE: begin
                shadow_frame[addr] = wd.pix;
            end
            KIND_ALPHA: begin
                if (alpha == ALPHA_OPAQUE) begin
                    shadow_frame[addr] = wd.pix;
                end else if (alpha != ALPHA_CLEAR) begin
                    dst     = shadow_frame.exists(addr) ? shadow_frame[addr] : '0;
                    blended = ARGB_BLACK;
                    for (ch = 0; ch < 3; ch++) begin
                        s  = int'(wd.pix[ch*8 +: 8]);
                        dc = int'(dst[ch*8 +: 8]);
                        blended[ch*8 +: 8] = 8'((s * alpha + dc * (255 - alpha)) / 255);
                    end
                    shadow_frame[addr] = blended;
                end
            end
            KIND_CURSOR: begin
                if (wd.code == CURSOR_BLACK) begin
                    shadow_frame[addr] = ARGB_BLACK;
                end else if (wd.code == CURSOR_WHITE) begin
                    shadow_frame[addr] = ARGB_WHITE;
                end
            end
            KIND_READ: begin
                r.pix = shadow_frame.exists(addr) ? shadow_frame[addr] : '0;
            end
        endcase
        return r;
    endfunction

    // Random word, mostly aimed at a small corner so reads and blends hit
    // pixels already written.
    function automatic t_pixel_word random_word();
        t_pixel_word wd;
        int          w_e;
        int          h_e;
        int          xi;
        int          yi;
        int          sel;
        logic [7:0]  alpha;
        w_e     = act_w();
        h_e     = act_h();
        wd.kind = t_kind'($urandom_range(0, 3));
        sel     = $urandom_range(0, 99);
        if (w_e == 0 || h_e == 0 || sel < 18) begin
            xi = $urandom_range(0, 8191) - 4096;
            yi = $urandom_range(0, 8191) - 4096;
            case ($urandom_range(0, 4))
                0: xi = -int'($urandom_range(1, 4096));
                1: xi = $urandom_range(w_e, 4095);
                2: yi = -int'($urandom_range(1, 4096));
                3: yi = $urandom_range(h_e, 4095);
                default: ;
            endcase
        end else if (sel < 85) begin
            xi = $urandom_range(0, ((w_e < 8) ? w_e : 8) - 1);
            yi = $urandom_range(0, ((h_e < 4) ? h_e : 4) - 1);
        end else begin
            xi = $urandom_range(0, w_e - 1);
            yi = $urandom_range(0, h_e - 1);
        end
        wd.pos_x = xi[POS_W-1:0];
        wd.pos_y = yi[POS_W-1:0];
        case ($urandom_range(0, 3))
            0: alpha = ALPHA_CLEAR;
            1: alpha = ALPHA_OPAQUE;
            default: alpha = 8'($urandom);
        endcase
        wd.pix = {alpha, 24'($urandom)};
        case ($urandom_range(0, 9))
            0, 1, 2: wd.code = CURSOR_BLACK;
            3, 4, 5: wd.code = CURSOR_WHITE;
            default: wd.code = 8'($urandom);
        endcase
        // Never read back or blend onto a pixel that holds nothing yet: turn it into an opaque write.
        xi = int'(wd.pos_x);
        yi = int'(wd.pos_y);
        if (!off_screen(xi, yi) && !shadow_frame.exists(yi * w_e + xi)) begin
            if (wd.kind == KIND_READ || (wd.kind == KIND_ALPHA &&
                    alpha != ALPHA_OPAQUE && alpha != ALPHA_CLEAR)) begin
                wd.kind = KIND_OPAQUE;
            end
        end
        return wd;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_cnt++;
    endtask

    task automatic issue_word(input t_pixel_word wd, input bit known,
                              input t_scan_result typed);
        t_scan_result pred;
        i_start       <= 1'b1;
        i_kind        <= wd.kind;
        i_pos_x       <= wd.pos_x;
        i_pos_y       <= wd.pos_y;
        i_pixel_value <= wd.pix;
        i_cursor_code <= wd.code;
        do @(posedge i_clk); while (o_busy);
        pred = composite_pixel(wd);
        due_results.push_back(known ? typed : pred);
    endtask

    // Drop start for a random gap once the current burst is used up.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (due_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_ACTIVE_WIDTH) begin
            width_reg = data;
        end else if (idx == CFG_ACTIVE_HEIGHT) begin
            height_reg = data[AH_W-1:0];
        end
    endtask

    task automatic set_active_area(input logic [CFG_DATA_W-1:0] wdata,
                                   input logic [CFG_DATA_W-1:0] hdata);
        write_reg(CFG_ACTIVE_WIDTH, wdata);
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(CFG_ACTIVE_HEIGHT, hdata);
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic void add_row(input t_kind kind, input int xi, input int yi,
                                    input t_pixel pix, input logic [CODE_W-1:0] code,
                                    input bit known, input t_pixel rpix, input logic rclip);
        t_directed_row row;
        row.wd.kind  = kind;
        row.wd.pos_x = xi[POS_W-1:0];
        row.wd.pos_y = yi[POS_W-1:0];
        row.wd.pix   = pix;
        row.wd.code  = code;
        row.known    = known;
        row.res.pix  = rpix;
        row.res.clip = rclip;
        directed_rows.push_back(row);
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is a word.
    always @(posedge i_clk) begin
        t_scan_result exp_res;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                exp_res = due_results.pop_front();
                if (o_read_pixel !== exp_res.pix) begin
                    report_mismatch($sformatf("read_pixel %08h, expected %08h",
                                              o_read_pixel, exp_res.pix));
                end
                if (o_clipped !== exp_res.clip) begin
                    report_mismatch($sformatf("clipped %0b, expected %0b",
                                              o_clipped, exp_res.clip));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= STALL_LIMIT) begin
                    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                    $display("FAIL alpha_blend_frame_compositor");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] phase_w [NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_h [NUM_PHASES];
        t_scan_result          none;
        int                    p;
        int                    n;

        i_rst_n       <= 1'b0;
        i_start       <= 1'b0;
        i_kind        <= KIND_OPAQUE;
        i_pos_x       <= '0;
        i_pos_y       <= '0;
        i_pixel_value <= '0;
        i_cursor_code <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_ACTIVE_WIDTH;
        i_cfg_data    <= '0;
        none.pix      = '0;
        none.clip     = 1'b0;

        // Directed words, all at the reset area of 512 x 256.
        add_row(KIND_OPAQUE, 0, 0, 32'h1234_5678, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 0, 0, 32'h0, 8'h00, 1, 32'h1234_5678, 1'b0);
        add_row(KIND_OPAQUE, 511, 255, 32'hA5A5_A5A5, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 511, 255, 32'h0, 8'h00, 1, 32'hA5A5_A5A5, 1'b0);
        add_row(KIND_OPAQUE, 512, 0, 32'hFFFF_FFFF, 8'hFF, 1, 32'h0, 1'b1);
        add_row(KIND_READ, 0, 256, 32'h0, 8'h00, 1, 32'h0, 1'b1);
        add_row(KIND_ALPHA, -1, 0, 32'hFF00_0000, 8'h00, 1, 32'h0, 1'b1);
        add_row(KIND_CURSOR, 0, -4096, 32'h0, CURSOR_BLACK, 1, 32'h0, 1'b1);
        add_row(KIND_READ, 4095, 4095, 32'h0, 8'h00, 1, 32'h0, 1'b1);
        add_row(KIND_ALPHA, -4096, 5, 32'h80FF_FFFF, 8'h00, 1, 32'h0, 1'b1);
        add_row(KIND_ALPHA, 0, 0, 32'hFF10_2030, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 0, 0, 32'h0, 8'h00, 1, 32'hFF10_2030, 1'b0);
        add_row(KIND_ALPHA, 0, 0, 32'h00FF_FFFF, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 0, 0, 32'h0, 8'h00, 1, 32'hFF10_2030, 1'b0);
        add_row(KIND_ALPHA, 0, 0, 32'h80FF_FFFF, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 0, 0, 32'h0, 8'h00, 0, 32'h0, 1'b0);
        add_row(KIND_CURSOR, 1, 0, 32'h0, CURSOR_BLACK, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 1, 0, 32'h0, 8'h00, 1, ARGB_BLACK, 1'b0);
        add_row(KIND_CURSOR, 1, 0, 32'h0, CURSOR_WHITE, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 1, 0, 32'h0, 8'h00, 1, ARGB_WHITE, 1'b0);
        add_row(KIND_CURSOR, 1, 0, 32'h0, 8'hFE, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 1, 0, 32'h0, 8'h00, 1, ARGB_WHITE, 1'b0);
        add_row(KIND_ALPHA, 1, 0, 32'h0100_0000, 8'h00, 1, 32'h0, 1'b0);
        add_row(KIND_READ, 1, 0, 32'h0, 8'h00, 0, 32'h0, 1'b0);
        add_row(KIND_READ, 511, 255, 32'h0, 8'h00, 1, 32'hA5A5_A5A5, 1'b0);

        // Width, height: small, single pixel, saturating, zero, odd, back to reset.
        phase_w = '{10'd16, 10'd1, 10'd1023, 10'd0, 10'd300, 10'd512, 10'd37, 10'd512};
        phase_h = '{10'd8, 10'd1, 10'd511, 10'd256, 10'd100, 10'h200, 10'd200, 10'd256};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(1, 16);

        foreach (directed_rows[r]) begin
            issue_word(directed_rows[r].wd, directed_rows[r].known, directed_rows[r].res);
            pace_sender();
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            // Registers change only with nothing in flight.
            wait_drained();
            set_active_area(phase_w[p], phase_h[p]);
            for (n = 0; n < PHASE_WORDS; n++) begin
                issue_word(random_word(), 0, none);
                if ($urandom_range(0, 149) == 0) begin
                    wait_drained();
                end else begin
                    pace_sender();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS alpha_blend_frame_compositor");
        end else begin
            $display("FAIL alpha_blend_frame_compositor");
        end
        $finish;
    end

endmodule

### alpha_blend_frame_compositor.f
design/abfc_pkg.sv
design/alpha_blend_frame_compositor.sv
tb/sv/alpha_blend_frame_compositor_test.sv
